/* src/iirbq_pkg.sv */
// ---------------------------------------------------------------------------
// iirbq_pkg
// Shared types and constants of the cascaded biquad filter: sequencer states,
// datapath operations and the fixed-point limits of the history format.
// ---------------------------------------------------------------------------
`default_nettype none

package iirbq_pkg;

  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned COEF_W   = 32;
  localparam int unsigned HIST_W   = 48;
  localparam int unsigned INDEX_W  = 6;
  localparam int unsigned CNT_W    = 4;
  localparam int unsigned OPB_W    = 25;
  localparam int unsigned PROD_W   = 80;
  localparam int unsigned SUM_W    = 56;

  localparam logic REQ_FILTER = 1'b0;
  localparam logic REQ_WRITE  = 1'b1;

  localparam logic signed [SUM_W-1:0] H_MAX = 56'sh00_7FFF_FFFF_FFFF;
  localparam logic signed [SUM_W-1:0] H_MIN = -56'sh00_8000_0000_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GAIN,
    ST_RD1,
    ST_RD2,
    ST_CAP,
    ST_LO,
    ST_HI,
    ST_ACC,
    ST_DONE
  } iirbq_state_e;

  typedef enum logic [2:0] {
    MAC_NOP,
    MAC_GAIN,
    MAC_LO,
    MAC_HI,
    MAC_ACC
  } mac_op_e;

  typedef struct packed {
    mac_op_e op;
    logic    neg;
    logic    sat;
  } mac_ctrl_t;

endpackage

`default_nettype wire

/* src/iirbq_req_if.sv */
// ---------------------------------------------------------------------------
// iirbq_req_if
// Request channel: one word is a filter sample or a coefficient write.
// ---------------------------------------------------------------------------
`default_nettype none

interface iirbq_req_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic signed [23:0] sample_in;
  logic        [5:0]  coef_index;
  logic signed [31:0] coef_value;

  modport source (output valid, req_type, sample_in, coef_index, coef_value, input ready);
  modport sink   (input valid, req_type, sample_in, coef_index, coef_value, output ready);
endinterface

`default_nettype wire

/* src/iirbq_rsp_if.sv */
// ---------------------------------------------------------------------------
// iirbq_rsp_if
// Response channel: one word per request.
// ---------------------------------------------------------------------------
`default_nettype none

interface iirbq_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] sample_out;
  logic               saturated;
  logic               write_ack;

  modport source (output valid, sample_out, saturated, write_ack, input ready);
  modport sink   (input valid, sample_out, saturated, write_ack, output ready);
endinterface

`default_nettype wire

/* src/iirbq_ram.sv */
// ---------------------------------------------------------------------------
// iirbq_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module iirbq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 33
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* src/iirbq_mac.sv */
// ---------------------------------------------------------------------------
// iirbq_mac
// Shared multiply-accumulate unit: one 32x25 multiplier builds the gain
// product and the two halves of each coefficient*history product, then the
// rounded product is added to or subtracted from the running sum.
// ---------------------------------------------------------------------------
`default_nettype none

module iirbq_mac
  import iirbq_pkg::*;
(
  input  wire logic                       clk_i,
  input  wire mac_ctrl_t                  ctrl_i,
  input  wire logic signed [COEF_W-1:0]   coef_i,
  input  wire logic signed [SAMPLE_W-1:0] x_i,
  input  wire logic signed [HIST_W-1:0]   h_i,
  output logic signed [SUM_W-1:0]         sum_o
);

  logic signed [PROD_W-1:0]          prod_q, prod_d;
  logic signed [SUM_W-1:0]           sum_q, sum_d;
  logic signed [OPB_W-1:0]           opb;
  logic signed [COEF_W+OPB_W-1:0]    mul;
  logic signed [COEF_W+OPB_W-1:0]    gain_rnd;
  logic signed [PROD_W-29:0]         prod_rnd;
  logic signed [SUM_W-1:0]           acc;

  always_comb begin
    case (ctrl_i.op)
      MAC_GAIN: opb = OPB_W'(x_i);
      MAC_LO:   opb = $signed({1'b0, h_i[23:0]});
      default:  opb = OPB_W'($signed(h_i[47:24]));
    endcase
  end

  assign mul      = coef_i * opb;
  assign gain_rnd = (mul + 57'sd524288) >>> 20;
  assign prod_rnd = $signed(prod_q[PROD_W-1:28]);
  assign acc      = ctrl_i.neg ? (sum_q - SUM_W'(prod_rnd)) : (sum_q + SUM_W'(prod_rnd));

  always_comb begin
    prod_d = prod_q;
    sum_d  = sum_q;
    case (ctrl_i.op)
      MAC_GAIN: sum_d  = SUM_W'(gain_rnd);
      MAC_LO:   prod_d = PROD_W'(mul) + 80'sd134217728;
      MAC_HI:   prod_d = prod_q + (PROD_W'(mul) <<< 24);
      MAC_ACC: begin
        if (ctrl_i.sat && acc > H_MAX) begin
          sum_d = H_MAX;
        end else if (ctrl_i.sat && acc < H_MIN) begin
          sum_d = H_MIN;
        end else begin
          sum_d = acc;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    sum_q  <= sum_d;
  end

  assign sum_o = sum_q;

endmodule

`default_nettype wire

/* src/iir_biquad_cascade_df2.sv */
// ---------------------------------------------------------------------------
// iir_biquad_cascade_df2
// Cascaded direct-form-II biquad filter with a shared multiply-accumulate.
//
// Requests arrive on req_i as words: req_type 0 filters sample_in, req_type 1
// stores coef_value into slot coef_index (0 gain, then a1,a2,b1,b2 per
// section). Every request gives one word on rsp_o. cfg_we_i/cfg_wdata_i set
// the number of sections in use; the user must write them only while the
// block is idle, as the block itself does not enforce it. One request is
// processed at a time; req_i.ready is low while busy. A coefficient write
// passes through ST_DONE into the response register. A sample passes through
// ST_GAIN for the gain product, then per section in use through ST_RD1,
// ST_RD2 and ST_CAP to fetch the history and through ST_LO, ST_HI and ST_ACC
// for each coefficient product, each product passing twice through the
// 32x25 multiplier, then through ST_DONE to round and clip.
// Reset zeroes all coefficients and history through valid bits at once and
// sets the section count to 1; no clearing pass is needed.
// A stalled response is held in the output register; the block finishes the
// next request and then waits until that register is free.
// ---------------------------------------------------------------------------
`default_nettype none

module iir_biquad_cascade_df2
  import iirbq_pkg::*;
#(
  parameter int unsigned MAX_SECTIONS = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  iirbq_req_if.sink             req_i,
  iirbq_rsp_if.source           rsp_o,
  input  wire logic             cfg_we_i,
  input  wire logic [CNT_W-1:0] cfg_wdata_i
);

  localparam int unsigned COEF_DEPTH = 1 + 4 * MAX_SECTIONS;
  localparam int unsigned HIST_DEPTH = 2 * MAX_SECTIONS;
  localparam int unsigned CA_W       = $clog2(COEF_DEPTH);
  localparam int unsigned HA_W       = $clog2(HIST_DEPTH);
  localparam int unsigned SC_W       = $clog2(MAX_SECTIONS + 1);

  iirbq_state_e               state_q, state_d;
  logic [CNT_W-1:0]           cfg_q;
  logic [SC_W-1:0]            n_eff;
  logic [SC_W-1:0]            sec_q, sec_d;
  logic [1:0]                 k_q, k_d;
  logic                       is_wr_q, is_wr_d;
  logic                       ack_q, ack_d;
  logic signed [SAMPLE_W-1:0] x_q, x_d;
  logic signed [HIST_W-1:0]   h1_q, h1_d, h2_q, h2_d;

  logic [COEF_DEPTH-1:0]      coef_vld_q;
  logic [HIST_DEPTH-1:0]      hist_vld_q;
  logic                       coef_rd_vld_q, hist_rd_vld_q;

  logic                       coef_we;
  logic [CA_W-1:0]            coef_waddr, coef_raddr;
  logic [COEF_W-1:0]          coef_rdata;
  logic                       hist_we;
  logic [HA_W-1:0]            hist_waddr, hist_raddr;
  logic [HIST_W-1:0]          hist_wdata, hist_rdata;

  logic signed [COEF_W-1:0]   coef_op;
  logic signed [HIST_W-1:0]   hist_op;
  logic signed [SUM_W-1:0]    sum;
  mac_ctrl_t                  mac_ctrl;

  logic                       out_vld_q, out_vld_d;
  logic signed [SAMPLE_W-1:0] out_smp_q, out_smp_d;
  logic                       out_sat_q, out_sat_d;
  logic                       out_ack_q, out_ack_d;
  logic signed [48:0]         y_rnd;
  logic signed [40:0]         y_full;
  logic                       out_free;

  always_comb begin
    if (32'(cfg_q) > MAX_SECTIONS) begin
      n_eff = SC_W'(MAX_SECTIONS);
    end else begin
      n_eff = SC_W'(cfg_q);
    end
  end

  assign coef_op  = coef_rd_vld_q ? $signed(coef_rdata) : '0;
  assign hist_op  = hist_rd_vld_q ? $signed(hist_rdata) : '0;
  assign out_free = !out_vld_q || rsp_o.ready;

  assign y_rnd  = $signed({sum[47], sum[47:0]}) + 49'sd128;
  assign y_full = y_rnd[48:8];

  always_comb begin
    state_d    = state_q;
    sec_d      = sec_q;
    k_d        = k_q;
    is_wr_d    = is_wr_q;
    ack_d      = ack_q;
    x_d        = x_q;
    h1_d       = h1_q;
    h2_d       = h2_q;
    req_i.ready = 1'b0;
    coef_we    = 1'b0;
    coef_waddr = CA_W'(req_i.coef_index);
    coef_raddr = '0;
    hist_we    = 1'b0;
    hist_waddr = HA_W'(32'(sec_q) * 2);
    hist_wdata = sum[HIST_W-1:0];
    hist_raddr = HA_W'(32'(sec_q) * 2);
    mac_ctrl   = '{op: MAC_NOP, neg: 1'b0, sat: 1'b0};
    out_vld_d  = out_vld_q && !rsp_o.ready;
    out_smp_d  = out_smp_q;
    out_sat_d  = out_sat_q;
    out_ack_d  = out_ack_q;

    case (state_q)
      ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          if (req_i.req_type == REQ_WRITE) begin
            is_wr_d = 1'b1;
            ack_d   = 32'(req_i.coef_index) < COEF_DEPTH;
            coef_we = 32'(req_i.coef_index) < COEF_DEPTH;
            state_d = ST_DONE;
          end else begin
            is_wr_d = 1'b0;
            ack_d   = 1'b0;
            x_d     = req_i.sample_in;
            state_d = ST_GAIN;
          end
        end
      end
      ST_GAIN: begin
        mac_ctrl.op = MAC_GAIN;
        sec_d       = '0;
        state_d     = (n_eff == '0) ? ST_DONE : ST_RD1;
      end
      ST_RD1: begin
        coef_raddr = CA_W'(32'(sec_q) * 4 + 1);
        state_d    = ST_RD2;
      end
      ST_RD2: begin
        coef_raddr = CA_W'(32'(sec_q) * 4 + 1);
        hist_raddr = HA_W'(32'(sec_q) * 2 + 1);
        h1_d       = hist_op;
        state_d    = ST_CAP;
      end
      ST_CAP: begin
        coef_raddr = CA_W'(32'(sec_q) * 4 + 1);
        h2_d       = hist_op;
        hist_we    = 1'b1;
        hist_waddr = HA_W'(32'(sec_q) * 2 + 1);
        hist_wdata = h1_q;
        k_d        = '0;
        state_d    = ST_LO;
      end
      ST_LO: begin
        coef_raddr  = CA_W'(32'(sec_q) * 4 + 1 + 32'(k_q));
        mac_ctrl.op = MAC_LO;
        if (k_q == 2'd2) begin
          hist_we = 1'b1;
        end
        state_d = ST_HI;
      end
      ST_HI: begin
        coef_raddr  = (k_q == 2'd3) ? CA_W'(32'(sec_q) * 4 + 4)
                                    : CA_W'(32'(sec_q) * 4 + 2 + 32'(k_q));
        mac_ctrl.op = MAC_HI;
        state_d     = ST_ACC;
      end
      ST_ACC: begin
        coef_raddr = (k_q == 2'd3) ? CA_W'(32'(sec_q) * 4 + 4)
                                   : CA_W'(32'(sec_q) * 4 + 2 + 32'(k_q));
        mac_ctrl   = '{op: MAC_ACC, neg: !k_q[1], sat: k_q[0]};
        k_d        = k_q + 2'd1;
        if (k_q == 2'd3) begin
          if (32'(sec_q) + 1 == 32'(n_eff)) begin
            state_d = ST_DONE;
          end else begin
            sec_d   = sec_q + SC_W'(1);
            state_d = ST_RD1;
          end
        end else begin
          state_d = ST_LO;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          out_ack_d = is_wr_q && ack_q;
          if (is_wr_q) begin
            out_smp_d = '0;
            out_sat_d = 1'b0;
          end else if (y_full > 41'sd8388607) begin
            out_smp_d = 24'sh7FFFFF;
            out_sat_d = 1'b1;
          end else if (y_full < -41'sd8388608) begin
            out_smp_d = -24'sh800000;
            out_sat_d = 1'b1;
          end else begin
            out_smp_d = y_full[SAMPLE_W-1:0];
            out_sat_d = 1'b0;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      cfg_q         <= CNT_W'(1);
      sec_q         <= '0;
      k_q           <= '0;
      is_wr_q       <= 1'b0;
      ack_q         <= 1'b0;
      coef_vld_q    <= '0;
      hist_vld_q    <= '0;
      coef_rd_vld_q <= 1'b0;
      hist_rd_vld_q <= 1'b0;
      out_vld_q     <= 1'b0;
    end else begin
      state_q       <= state_d;
      sec_q         <= sec_d;
      k_q           <= k_d;
      is_wr_q       <= is_wr_d;
      ack_q         <= ack_d;
      out_vld_q     <= out_vld_d;
      coef_rd_vld_q <= coef_vld_q[coef_raddr];
      hist_rd_vld_q <= hist_vld_q[hist_raddr];
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (coef_we) begin
        coef_vld_q[coef_waddr] <= 1'b1;
      end
      if (hist_we) begin
        hist_vld_q[hist_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q       <= x_d;
    h1_q      <= h1_d;
    h2_q      <= h2_d;
    out_smp_q <= out_smp_d;
    out_sat_q <= out_sat_d;
    out_ack_q <= out_ack_d;
  end

  iirbq_ram #(
    .WIDTH (COEF_W),
    .DEPTH (COEF_DEPTH)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (coef_waddr),
    .wdata_i (req_i.coef_value),
    .raddr_i (coef_raddr),
    .rdata_o (coef_rdata)
  );

  iirbq_ram #(
    .WIDTH (HIST_W),
    .DEPTH (HIST_DEPTH)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (hist_waddr),
    .wdata_i (hist_wdata),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rdata)
  );

  iirbq_mac u_mac (
    .clk_i  (clk_i),
    .ctrl_i (mac_ctrl),
    .coef_i (coef_op),
    .x_i    (x_q),
    .h_i    (k_q[0] ? h2_q : h1_q),
    .sum_o  (sum)
  );

  assign rsp_o.valid      = out_vld_q;
  assign rsp_o.sample_out = out_smp_q;
  assign rsp_o.saturated  = out_sat_q;
  assign rsp_o.write_ack  = out_ack_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("request accepted while a previous one is in flight");

  a_write_rsp_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.write_ack |-> !rsp_o.saturated && rsp_o.sample_out == '0)
    else $error("write acknowledge carries sample data");

  a_section_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ACC |-> sec_q < n_eff)
    else $error("section counter beyond sections in use");

  a_result_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE && !out_free |=> state_q == ST_DONE && $stable(sum))
    else $error("result lost while response register is full");

endmodule

`default_nettype wire

/* tb/tb.sv */
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the cascaded biquad filter. A mirror of the
// coefficient and history stores predicts every response word in fixed
// point when its request is accepted. Responses are compared field by field
// as they are accepted. Directed cases cover store edges, gain clipping,
// section count edges and history overflow. A backpressure burst follows,
// then random filter programs and samples under four idling modes.
// ---------------------------------------------------------------------------
`default_nettype none

module tb
  import iirbq_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSEC          = 8;
  localparam int COEF_SLOTS    = 1 + 4 * NSEC;
  localparam int GAIN_SLOT     = 0;
  localparam int A1_OFS        = 1;
  localparam int A2_OFS        = 2;
  localparam int B1_OFS        = 3;
  localparam int B2_OFS        = 4;
  localparam int LAST_INDEX    = 63;
  localparam int UNIT_COEF     = 1 << 28;
  localparam int RESET_CYCLES  = 5;
  localparam int SETTLE_CYCLES = 130;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_ITEMS  = 1200;
  localparam int MAX_REPORTS   = 40;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  localparam logic signed [127:0] HIST_TOP = (128'sd1 <<< 47) - 128'sd1;
  localparam logic signed [127:0] HIST_BOT = -(128'sd1 <<< 47);

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       saturated;
    logic                       write_ack;
  } bq_word_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CNT_W-1:0] cfg_wdata_i;

  iirbq_req_if req_if ();
  iirbq_rsp_if rsp_if ();

  logic signed [COEF_W-1:0] coef_mirror [0:COEF_SLOTS-1];
  logic signed [HIST_W-1:0] hist_mirror [0:2*NSEC-1];
  logic [CNT_W-1:0]         sect_cnt_mirror;
  bq_word_t                 expected_words [$];

  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_len;
  int          hold_id;
  int          sent_cnt;
  int          done_cnt;
  int          err_cnt;
  int unsigned cycle_cnt;

  iir_biquad_cascade_df2 #(
    .MAX_SECTIONS(NSEC)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Fixed-point mirror of the filter
  // ---------------------------------------------------------------------------
  function automatic logic signed [127:0] coef_times_hist(logic signed [COEF_W-1:0] c,
                                                         logic signed [HIST_W-1:0] h);
    logic signed [127:0] cw;
    logic signed [127:0] hw;
    cw = c;
    hw = h;
    return (cw * hw + (128'sd1 <<< 27)) >>> 28;
  endfunction

  function automatic logic signed [127:0] clamp_hist(logic signed [127:0] v);
    if (v > HIST_TOP) return HIST_TOP;
    if (v < HIST_BOT) return HIST_BOT;
    return v;
  endfunction

  function automatic bq_word_t biquad_filter_sample(logic signed [SAMPLE_W-1:0] x);
    logic signed [127:0] acc;
    logic signed [127:0] w;
    logic signed [127:0] xw;
    logic signed [127:0] gw;
    logic signed [127:0] h1;
    logic signed [127:0] h2;
    logic signed [127:0] yq;
    int                  n;
    int                  b;
    bq_word_t            r;
    xw = x;
    gw = coef_mirror[GAIN_SLOT];
    acc = (xw * gw + (128'sd1 <<< 19)) >>> 20;
    n = (sect_cnt_mirror > NSEC) ? NSEC : int'(sect_cnt_mirror);
    for (int i = 0; i < n; i++) begin
      b = 4 * i;
      h1 = hist_mirror[2*i];
      h2 = hist_mirror[2*i+1];
      w = clamp_hist(acc - coef_times_hist(coef_mirror[b+A1_OFS], h1[HIST_W-1:0])
                         - coef_times_hist(coef_mirror[b+A2_OFS], h2[HIST_W-1:0]));
      acc = clamp_hist(w + coef_times_hist(coef_mirror[b+B1_OFS], h1[HIST_W-1:0])
                         + coef_times_hist(coef_mirror[b+B2_OFS], h2[HIST_W-1:0]));
      hist_mirror[2*i+1] = h1[HIST_W-1:0];
      hist_mirror[2*i]   = w[HIST_W-1:0];
    end
    yq = (acc + 128'sd128) >>> 8;
    r.write_ack = 1'b0;
    r.saturated = 1'b0;
    if (yq > 128'sd8388607) begin
      r.sample_out = 24'sh7FFFFF;
      r.saturated  = 1'b1;
    end else if (yq < -128'sd8388608) begin
      r.sample_out = 24'sh800000;
      r.saturated  = 1'b1;
    end else begin
      r.sample_out = yq[SAMPLE_W-1:0];
    end
    return r;
  endfunction

  function automatic bq_word_t store_coef_word(logic [INDEX_W-1:0] idx,
                                               logic signed [COEF_W-1:0] val);
    bq_word_t r;
    r.sample_out = '0;
    r.saturated  = 1'b0;
    r.write_ack  = 1'b0;
    if (idx < COEF_SLOTS) begin
      coef_mirror[idx] = val;
      r.write_ack      = 1'b1;
    end
    return r;
  endfunction

  task automatic report_error(string msg);
    if (err_cnt < MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  // ---------------------------------------------------------------------------
  // Predict on request words, check response words
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    bq_word_t want;
    if (!rst_ni) begin
      sect_cnt_mirror = CNT_W'(1);
      foreach (coef_mirror[k]) coef_mirror[k] = '0;
      foreach (hist_mirror[k]) hist_mirror[k] = '0;
    end else begin
      if (cfg_we_i) sect_cnt_mirror = cfg_wdata_i;
      if (req_if.valid && req_if.ready) begin
        if (req_if.req_type == REQ_WRITE)
          expected_words.push_back(store_coef_word(req_if.coef_index, req_if.coef_value));
        else
          expected_words.push_back(biquad_filter_sample(req_if.sample_in));
      end
      if (rsp_if.valid && rsp_if.ready) begin
        done_cnt++;
        if (expected_words.size() == 0) begin
          report_error($sformatf("word %0d: no word expected", done_cnt));
        end else begin
          want = expected_words.pop_front();
          if (rsp_if.sample_out !== want.sample_out)
            report_error($sformatf("word %0d sample_out: expected %0d, got %0d",
                                   done_cnt, want.sample_out, rsp_if.sample_out));
          if (rsp_if.saturated !== want.saturated)
            report_error($sformatf("word %0d saturated: expected %0b, got %0b",
                                   done_cnt, want.saturated, rsp_if.saturated));
          if (rsp_if.write_ack !== want.write_ack)
            report_error($sformatf("word %0d write_ack: expected %0b, got %0b",
                                   done_cnt, want.write_ack, rsp_if.write_ack));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Response side: random stalls and long hold-offs
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    int hold_seen;
    int hold_left;
    if (hold_id != hold_seen) begin
      hold_seen = hold_id;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic send_word(input logic rt, input logic signed [SAMPLE_W-1:0] smp,
                           input logic [INDEX_W-1:0] idx,
                           input logic signed [COEF_W-1:0] val);
    if ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    req_if.valid      <= 1'b1;
    req_if.req_type   <= rt;
    req_if.sample_in  <= smp;
    req_if.coef_index <= idx;
    req_if.coef_value <= val;
    do @(posedge clk_i); while (!req_if.ready);
    sent_cnt++;
  endtask

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp);
    send_word(REQ_FILTER, smp, '0, '0);
  endtask

  task automatic send_coef(input int idx, input logic signed [COEF_W-1:0] val);
    send_word(REQ_WRITE, '0, INDEX_W'(idx), val);
  endtask

  task automatic wait_for_results();
    req_if.valid <= 1'b0;
    while (done_cnt < sent_cnt) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_section_count(input logic [CNT_W-1:0] n);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= n;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic set_idle_mode(input int mode);
    case (mode)
      0: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct  = 87;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct  = 0;
        recv_stall_pct = 87;
      end
      default: begin
        send_idle_pct  = 21;
        recv_stall_pct = 21;
      end
    endcase
  endtask

  function automatic logic signed [COEF_W-1:0] rand_coef(int mag);
    if ($urandom_range(9) == 0) return $urandom;
    return int'($urandom_range(2 * mag)) - mag;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(19))
      0:       return 24'sh7FFFFF;
      1:       return 24'sh800000;
      2, 3, 4: return SAMPLE_W'(int'($urandom_range(1 << 17)) - (1 << 16));
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // mostly stable pole pairs, with rare full-range words
  task automatic program_filter(input int nsec);
    int a2;
    int a1_lim;
    send_coef(GAIN_SLOT, rand_coef(UNIT_COEF));
    for (int s = 0; s < nsec; s++) begin
      a2     = int'($urandom_range(460_000_000)) - 230_000_000;
      a1_lim = (UNIT_COEF + a2) / 8 * 7;
      send_coef(1 + 4 * s + A1_OFS - 1, rand_coef(a1_lim));
      send_coef(1 + 4 * s + A2_OFS - 1, a2);
      send_coef(1 + 4 * s + B1_OFS - 1, rand_coef(UNIT_COEF));
      send_coef(1 + 4 * s + B2_OFS - 1, rand_coef(UNIT_COEF));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_reset_state();
    send_sample(24'sh7FFFFF);
    send_sample(24'sh800000);
  endtask

  task automatic test_coef_writes();
    send_coef(GAIN_SLOT, 32'sh1000_0000);
    send_coef(COEF_SLOTS - 1, 32'sh7FFF_FFFF);
    send_coef(COEF_SLOTS, -32'sd1);
    send_coef(LAST_INDEX, 32'sh8000_0000);
  endtask

  task automatic test_gain_clip();
    send_coef(GAIN_SLOT, 32'sh7FFF_FFFF);
    send_sample(24'sh7FFFFF);
    send_sample(24'sh800000);
    send_sample(24'sh000000);
    send_coef(GAIN_SLOT, 32'sh8000_0000);
    send_sample(24'sh800000);
  endtask

  task automatic test_section_count();
    wait_for_results();
    write_section_count(CNT_W'(0));
    send_sample(24'sh123456);
    send_coef(GAIN_SLOT, 32'sh1000_0000);
    send_sample(24'sh000001);
    wait_for_results();
    write_section_count(CNT_W'(15));
    send_coef(A1_OFS, 32'sh8000_0000);
    send_coef(B1_OFS, 32'sh7FFF_FFFF);
    repeat (6) send_sample(24'sh7FFFFF);
    wait_for_results();
  endtask

  task automatic test_output_stall();
    set_idle_mode(0);
    write_section_count(CNT_W'(NSEC));
    program_filter(NSEC);
    hold_len = HOLD_CYCLES;
    hold_id++;
    repeat (8) send_sample(rand_sample());
    wait_for_results();
  endtask

  task automatic test_random_traffic();
    int base;
    int ignored;
    int seg;
    int n;
    int idx;
    base    = sent_cnt;
    ignored = 0;
    seg     = 0;
    while (sent_cnt - base - ignored < RANDOM_ITEMS) begin
      wait_for_results();
      set_idle_mode(seg % 4);
      case (seg)
        0:       n = NSEC;
        1:       n = 0;
        2:       n = 15;
        3:       n = 1;
        default: n = $urandom_range(15);
      endcase
      write_section_count(CNT_W'(n));
      program_filter((n == 0) ? 1 : ((n > NSEC) ? NSEC : n));
      repeat ($urandom_range(90, 50)) begin
        if ($urandom_range(99) < 12) begin
          idx = $urandom_range(LAST_INDEX);
          if (idx >= COEF_SLOTS) ignored++;
          send_coef(idx, $urandom);
        end else begin
          send_sample(rand_sample());
        end
      end
      seg++;
    end
  endtask

  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = '0;
    req_if.valid      = 1'b0;
    req_if.req_type   = REQ_FILTER;
    req_if.sample_in  = '0;
    req_if.coef_index = '0;
    req_if.coef_value = '0;
    rsp_if.ready      = 1'b0;
    cycle_cnt         = 0;
    hold_len          = 0;
    hold_id           = 0;
    sent_cnt          = 0;
    done_cnt          = 0;
    err_cnt           = 0;
    set_idle_mode(0);
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_coef_writes();
    test_gain_clip();
    test_section_count();
    test_output_stall();
    test_random_traffic();

    wait_for_results();
    if (expected_words.size() != 0)
      report_error($sformatf("%0d words never arrived", expected_words.size()));
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
